// ===== hdl/sbcp_pkg.sv =====
// Shared types and constants for the sphere/box collision push-out pipeline.
// No dependencies.
`default_nettype none
package sbcp_pkg;

    localparam int unsigned CW   = 16;   // coordinate width, Q7.8
    localparam int unsigned RW   = 12;   // radius width, Q4.8
    localparam int unsigned MW   = 12;   // axis offset magnitude on a hit
    localparam int unsigned SQW  = 20;   // distance width, Q.16
    localparam int unsigned VW   = 40;   // sqrt operand width
    localparam int unsigned REMW = 22;   // sqrt remainder width
    localparam int unsigned NW   = 33;   // divider numerator width
    localparam int unsigned DSW  = 32;   // shifted divisor width
    localparam int unsigned QW   = 12;   // push magnitude width

    localparam int unsigned PREP_STAGES  = 3;
    localparam int unsigned SQRT_STAGES  = 20;
    localparam int unsigned SCALE_STAGES = 2;
    localparam int unsigned DIV_STAGES   = 12;

    typedef struct packed {
        logic [2:0][CW-1:0] ctr;     // sphere center
        logic               hit;
        logic               push_en; // hit with nonzero distance
        logic [2:0]         dpos;    // offset to closest point is positive
        logic [2:0][MW-1:0] mag;     // |offset|
        logic [RW-1:0]      rad;
    } t_side;

endpackage
`default_nettype wire

// ===== hdl/sbcp_prep.sv =====
// Front end: clamp, per-axis offsets, squares, squared distance and hit test.
// Three register stages. Depends on sbcp_pkg.
`default_nettype none
module sbcp_prep (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire  [2:0][sbcp_pkg::CW-1:0]     i_ctr,
    input  wire  [2:0][sbcp_pkg::CW-1:0]     i_lo,
    input  wire  [2:0][sbcp_pkg::CW-1:0]     i_hi,
    input  wire  [sbcp_pkg::RW-1:0]          i_rad,
    output sbcp_pkg::t_side                  o_side,
    output logic [sbcp_pkg::VW-1:0]          o_v
);
    logic [2:0][sbcp_pkg::CW-1:0] r_ctr1, r_ctr2;
    logic [2:0][16:0]             r_d, n_d;
    logic [sbcp_pkg::RW-1:0]      r_rad1;
    logic [2:0][31:0]             r_sq, n_sq;
    logic [23:0]                  r_rr;
    logic [2:0]                   r_dpos, n_dpos;
    logic [2:0][sbcp_pkg::MW-1:0] r_mag, n_mag;
    logic [sbcp_pkg::RW-1:0]      r_rad2;
    sbcp_pkg::t_side              r_side, n_side;
    logic [sbcp_pkg::VW-1:0]      r_v;
    logic [33:0]                  d2;

    always_comb begin
        logic signed [15:0] c, lo, hi, t, cl;
        logic signed [16:0] dv;
        logic [16:0]        ad;
        for (int i = 0; i < 3; i++) begin
            c  = $signed(i_ctr[i]);
            lo = $signed(i_lo[i]);
            hi = $signed(i_hi[i]);
            t  = (c < hi) ? c : hi;
            cl = (lo > t) ? lo : t;
            n_d[i] = 17'($signed({cl[15], cl}) - $signed({c[15], c}));
            dv = $signed(r_d[i]);
            ad = dv[16] ? 17'(-dv) : 17'(dv);
            n_sq[i] = 32'(ad) * 32'(ad);
            n_mag[i] = ad[sbcp_pkg::MW-1:0];
            n_dpos[i] = !dv[16] && (dv != 17'sd0);
        end
        d2 = 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
        n_side.ctr     = r_ctr2;
        n_side.hit     = d2 < 34'(r_rr);
        n_side.push_en = (d2 < 34'(r_rr)) && (d2 != 34'd0);
        n_side.dpos    = r_dpos;
        n_side.mag     = r_mag;
        n_side.rad     = r_rad2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctr1 <= i_ctr;
            r_d    <= n_d;
            r_rad1 <= i_rad;
            r_ctr2 <= r_ctr1;
            r_sq   <= n_sq;
            r_rr   <= 24'(r_rad1) * 24'(r_rad1);
            r_dpos <= n_dpos;
            r_mag  <= n_mag;
            r_rad2 <= r_rad1;
            r_side <= n_side;
            r_v    <= {d2[23:0], 16'h0000};
        end
    end

    assign o_side = r_side;
    assign o_v    = r_v;
endmodule
`default_nettype wire

// ===== hdl/sbcp_sqrt_stage.sv =====
// One bit of the pipelined integer square root (two operand bits per stage).
// Depends on sbcp_pkg.
`default_nettype none
module sbcp_sqrt_stage (
    input  wire                           i_clk,
    input  wire                           i_en,
    input  wire  sbcp_pkg::t_side         i_side,
    input  wire  [sbcp_pkg::VW-1:0]       i_v,
    input  wire  [sbcp_pkg::REMW-1:0]     i_rem,
    input  wire  [sbcp_pkg::SQW-1:0]      i_root,
    output sbcp_pkg::t_side               o_side,
    output logic [sbcp_pkg::VW-1:0]       o_v,
    output logic [sbcp_pkg::REMW-1:0]     o_rem,
    output logic [sbcp_pkg::SQW-1:0]      o_root
);
    sbcp_pkg::t_side              r_side;
    logic [sbcp_pkg::VW-1:0]      r_v;
    logic [sbcp_pkg::REMW-1:0]    r_rem, n_rem;
    logic [sbcp_pkg::SQW-1:0]     r_root, n_root;
    logic [sbcp_pkg::REMW:0]      rsh, trial;

    always_comb begin
        rsh   = {i_rem[sbcp_pkg::REMW-2:0], i_v[sbcp_pkg::VW-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        if (rsh >= trial) begin
            n_rem  = sbcp_pkg::REMW'(rsh - trial);
            n_root = {i_root[sbcp_pkg::SQW-2:0], 1'b1};
        end else begin
            n_rem  = sbcp_pkg::REMW'(rsh);
            n_root = {i_root[sbcp_pkg::SQW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_v    <= {i_v[sbcp_pkg::VW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_side = r_side;
    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== hdl/sbcp_scale.sv =====
// Overlap times offset magnitude, then numerator and divisor setup.
// Two register stages. Depends on sbcp_pkg.
`default_nettype none
module sbcp_scale (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire  sbcp_pkg::t_side            i_side,
    input  wire  [sbcp_pkg::SQW-1:0]         i_dist,
    output sbcp_pkg::t_side                  o_side,
    output logic [2:0][sbcp_pkg::NW-1:0]     o_num,
    output logic [sbcp_pkg::DSW-1:0]         o_den
);
    sbcp_pkg::t_side          r_side1, r_side2;
    logic [2:0][31:0]         r_prod;
    logic [sbcp_pkg::SQW-1:0] r_dist;
    logic [2:0][sbcp_pkg::NW-1:0] r_num;
    logic [sbcp_pkg::DSW-1:0] r_den;
    logic [sbcp_pkg::SQW-1:0] over;

    assign over = {i_side.rad, 8'h00} - i_dist;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_dist  <= i_dist;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= 32'(over) * 32'(i_side.mag[i]);
                r_num[i]  <= sbcp_pkg::NW'(r_prod[i]) + sbcp_pkg::NW'(r_dist);
            end
            r_side2 <= r_side1;
            r_den   <= {r_dist, 12'h000};
        end
    end

    assign o_side = r_side2;
    assign o_num  = r_num;
    assign o_den  = r_den;
endmodule
`default_nettype wire

// ===== hdl/sbcp_div_stage.sv =====
// One quotient bit of the three restoring dividers sharing a divisor.
// Depends on sbcp_pkg.
`default_nettype none
module sbcp_div_stage (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire  sbcp_pkg::t_side            i_side,
    input  wire  [2:0][sbcp_pkg::NW-1:0]     i_num,
    input  wire  [sbcp_pkg::DSW-1:0]         i_den,
    input  wire  [2:0][sbcp_pkg::QW-1:0]     i_q,
    output sbcp_pkg::t_side                  o_side,
    output logic [2:0][sbcp_pkg::NW-1:0]     o_num,
    output logic [sbcp_pkg::DSW-1:0]         o_den,
    output logic [2:0][sbcp_pkg::QW-1:0]     o_q
);
    sbcp_pkg::t_side                  r_side;
    logic [2:0][sbcp_pkg::NW-1:0]     r_num, n_num;
    logic [sbcp_pkg::DSW-1:0]         r_den;
    logic [2:0][sbcp_pkg::QW-1:0]     r_q, n_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_num[i] >= sbcp_pkg::NW'(i_den)) begin
                n_num[i] = i_num[i] - sbcp_pkg::NW'(i_den);
                n_q[i]   = {i_q[i][sbcp_pkg::QW-2:0], 1'b1};
            end else begin
                n_num[i] = i_num[i];
                n_q[i]   = {i_q[i][sbcp_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_num  <= n_num;
            r_den  <= i_den >> 1;
            r_q    <= n_q;
        end
    end

    assign o_side = r_side;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_q    = r_q;
endmodule
`default_nettype wire

// ===== hdl/sphere_box_collision_pushout_unit.sv =====
// Sphere versus axis-aligned box collision with push-out, top level.
// Depends on sbcp_pkg, sbcp_prep, sbcp_sqrt_stage, sbcp_scale, sbcp_div_stage.
//
// Usage:
//   Input channel: i_valid / o_stall with the sphere and box fields. A
//   transaction is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with hit, push and new center. One
//   result per input transaction, in order.
//   Between an input transaction and o_valid lie 3 front-end stages, 20
//   square-root stages, 2 scaling stages, 12 divider stages and the output
//   register. Throughput: one transaction per cycle unless the pipeline is
//   held; the square root and the dividers retire one result bit per stage.
//   When a result waits with i_stall high, the whole pipeline holds and
//   o_stall is raised; nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
//   A center inside the box with nonzero radius reports a hit with zero push.
`default_nettype none
module sphere_box_collision_pushout_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_sphere_x,
    input  wire  [15:0] i_sphere_y,
    input  wire  [15:0] i_sphere_z,
    input  wire  [11:0] i_sphere_radius,
    input  wire  [15:0] i_box_min_x,
    input  wire  [15:0] i_box_max_x,
    input  wire  [15:0] i_box_min_y,
    input  wire  [15:0] i_box_max_y,
    input  wire  [15:0] i_box_min_z,
    input  wire  [15:0] i_box_max_z,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_hit,
    output logic [15:0] o_push_x,
    output logic [15:0] o_push_y,
    output logic [15:0] o_push_z,
    output logic [15:0] o_new_x,
    output logic [15:0] o_new_y,
    output logic [15:0] o_new_z
);
    localparam int unsigned NST = sbcp_pkg::PREP_STAGES + sbcp_pkg::SQRT_STAGES
                                + sbcp_pkg::SCALE_STAGES + sbcp_pkg::DIV_STAGES + 1;

    logic           adv;
    logic [NST-1:0] r_vld;

    sbcp_pkg::t_side                  sq_side [sbcp_pkg::SQRT_STAGES+1];
    logic [sbcp_pkg::VW-1:0]          sq_v    [sbcp_pkg::SQRT_STAGES+1];
    logic [sbcp_pkg::REMW-1:0]        sq_rem  [sbcp_pkg::SQRT_STAGES+1];
    logic [sbcp_pkg::SQW-1:0]         sq_root [sbcp_pkg::SQRT_STAGES+1];

    sbcp_pkg::t_side                  dv_side [sbcp_pkg::DIV_STAGES+1];
    logic [2:0][sbcp_pkg::NW-1:0]     dv_num  [sbcp_pkg::DIV_STAGES+1];
    logic [sbcp_pkg::DSW-1:0]         dv_den  [sbcp_pkg::DIV_STAGES+1];
    logic [2:0][sbcp_pkg::QW-1:0]     dv_q    [sbcp_pkg::DIV_STAGES+1];

    logic        r_hit;
    logic [2:0][15:0] r_push, n_push, r_new, n_new;

    assign adv     = !(r_vld[NST-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    sbcp_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_ctr  ({i_sphere_z, i_sphere_y, i_sphere_x}),
        .i_lo   ({i_box_min_z, i_box_min_y, i_box_min_x}),
        .i_hi   ({i_box_max_z, i_box_max_y, i_box_max_x}),
        .i_rad  (i_sphere_radius),
        .o_side (sq_side[0]),
        .o_v    (sq_v[0])
    );
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < sbcp_pkg::SQRT_STAGES; g++) begin : g_sqrt
        sbcp_sqrt_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_side (sq_side[g]),
            .i_v    (sq_v[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .o_side (sq_side[g+1]),
            .o_v    (sq_v[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1])
        );
    end

    sbcp_scale u_scale (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_side (sq_side[sbcp_pkg::SQRT_STAGES]),
        .i_dist (sq_root[sbcp_pkg::SQRT_STAGES]),
        .o_side (dv_side[0]),
        .o_num  (dv_num[0]),
        .o_den  (dv_den[0])
    );
    assign dv_q[0] = '0;

    for (genvar g = 0; g < sbcp_pkg::DIV_STAGES; g++) begin : g_div
        sbcp_div_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_side (dv_side[g]),
            .i_num  (dv_num[g]),
            .i_den  (dv_den[g]),
            .i_q    (dv_q[g]),
            .o_side (dv_side[g+1]),
            .o_num  (dv_num[g+1]),
            .o_den  (dv_den[g+1]),
            .o_q    (dv_q[g+1])
        );
    end

    always_comb begin
        logic signed [16:0] p;
        logic signed [17:0] s;
        sbcp_pkg::t_side    sd;
        sd = dv_side[sbcp_pkg::DIV_STAGES];
        for (int i = 0; i < 3; i++) begin
            p = $signed({5'b0, dv_q[sbcp_pkg::DIV_STAGES][i]});
            if (!sd.push_en)
                p = 17'sd0;
            else if (sd.dpos[i])
                p = -p;
            s = $signed({{2{sd.ctr[i][15]}}, sd.ctr[i]}) + $signed({p[16], p});
            n_push[i] = p[15:0];
            if (s > 18'sd32767)
                n_new[i] = 16'h7FFF;
            else if (s < -18'sd32768)
                n_new[i] = 16'h8000;
            else
                n_new[i] = s[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit  <= dv_side[sbcp_pkg::DIV_STAGES].hit;
            r_push <= n_push;
            r_new  <= n_new;
        end
    end

    assign o_valid  = r_vld[NST-1];
    assign o_hit    = r_hit;
    assign o_push_x = r_push[0];
    assign o_push_y = r_push[1];
    assign o_push_z = r_push[2];
    assign o_new_x  = r_new[0];
    assign o_new_y  = r_new[1];
    assign o_new_z  = r_new[2];
endmodule
`default_nettype wire

// ===== hdl/sbcp_checker.sv =====
// Port-level assertions for sphere_box_collision_pushout_unit, with bind.
// Depends on sphere_box_collision_pushout_unit.
`default_nettype none
module sbcp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_hit,
    input wire [15:0] o_push_x,
    input wire [15:0] o_push_y,
    input wire [15:0] o_push_z
);
    a_no_hit_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_push_x == 16'h0 && o_push_y == 16'h0 && o_push_z == 16'h0)
        else $error("push without hit");

    a_push_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_push_x[15:11] == 5'h00 || o_push_x[15:11] == 5'h1F)
                 && (o_push_y[15:11] == 5'h00 || o_push_y[15:11] == 5'h1F)
                 && (o_push_z[15:11] == 5'h00 || o_push_z[15:11] == 5'h1F))
        else $error("push magnitude out of range");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_push_x))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind sphere_box_collision_pushout_unit sbcp_checker u_sbcp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_hit    (o_hit),
    .o_push_x (o_push_x),
    .o_push_y (o_push_y),
    .o_push_z (o_push_z)
);
`default_nettype wire
